### rtl/motor_velocity_pid_unit_defines.svh
// Assertion shorthands shared by the RTL. Each one samples on the rising
// edge of clock and is disabled while reset is high.
`ifndef MOTOR_VELOCITY_PID_UNIT_DEFINES_SVH
`define MOTOR_VELOCITY_PID_UNIT_DEFINES_SVH

// Property holds at every edge.
`define MVP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define MVP_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication violated");

// Consequent holds in the cycle after the antecedent.
`define MVP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

### rtl/mvp_pkg.sv
package mvp_pkg;

   // Field widths
   localparam int SP_W     = 8;
   localparam int CLICKS_W = 16;
   localparam int DRIVE_W  = 8;
   localparam int ERR_W    = 17;
   localparam int DELTA_W  = ERR_W + 1;
   localparam int INTEG_W  = 32;
   localparam int ACC_W    = 14;
   localparam int GAIN_W   = 8;
   localparam int LIMIT_W  = 7;
   localparam int CSR_W    = 8;
   localparam int CSR_IDX_W = 3;

   // Product widths (signed operand times zero-extended gain)
   localparam int MP_W  = ERR_W + GAIN_W + 1;
   localparam int MD_W  = DELTA_W + GAIN_W + 1;
   localparam int MI_W  = INTEG_W + GAIN_W + 1;
   localparam int SUM_W = MI_W + 1;

   localparam int DRIVE_SHIFT = 6;
   localparam int LEAK_SHIFT  = 6;
   localparam int SETPOINT_MAX = 100;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 14'sd8128;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -14'sd8128;

   // Request queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOOP_MODE      = 3'd0,
      CSR_SPEED_LIMIT    = 3'd1,
      CSR_PD_PROP_GAIN   = 3'd2,
      CSR_PD_DERIV_GAIN  = 3'd3,
      CSR_PID_PROP_GAIN  = 3'd4,
      CSR_PID_INT_GAIN   = 3'd5,
      CSR_PID_DERIV_GAIN = 3'd6
   } csr_index_type;

   typedef enum logic {
      MODE_PD  = 1'b0,
      MODE_PID = 1'b1
   } loop_mode_type;

   typedef struct packed {
      loop_mode_type      loop_mode;
      logic [LIMIT_W-1:0] speed_cap;
      logic [GAIN_W-1:0]  pd_prop_gain;
      logic [GAIN_W-1:0]  pd_deriv_gain;
      logic [GAIN_W-1:0]  pid_prop_gain;
      logic [GAIN_W-1:0]  pid_int_gain;
      logic [GAIN_W-1:0]  pid_deriv_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      loop_mode:      MODE_PID,
      speed_cap:      7'd25,
      pd_prop_gain:   8'd3,
      pd_deriv_gain:  8'd4,
      pid_prop_gain:  8'd8,
      pid_int_gain:   8'd8,
      pid_deriv_gain: 8'd16
   };

   // Classified request: live is low for a stop or out-of-range setpoint
   typedef struct packed {
      logic                     live;
      loop_mode_type            mode;
      logic signed [ERR_W-1:0]  err;
   } item_type;

   typedef struct packed {
      logic                      live;
      loop_mode_type             mode;
      logic signed [ERR_W-1:0]   err;
      logic signed [DELTA_W-1:0] delta;
      logic signed [INTEG_W-1:0] integral;
   } state_stage_type;

   typedef struct packed {
      logic                   live;
      loop_mode_type          mode;
      logic signed [MP_W-1:0] m_prop;
      logic signed [MD_W-1:0] m_deriv;
      logic signed [MI_W-1:0] m_int;
   } mult_stage_type;

endpackage

### rtl/mvp_front.sv
module mvp_front (
   input  logic signed [mvp_pkg::SP_W-1:0]     req_setpoint,
   input  logic signed [mvp_pkg::CLICKS_W-1:0] req_clicks,
   input  mvp_pkg::cfg_type                    cfg,
   output mvp_pkg::item_type                   item
);
   import mvp_pkg::*;

   logic signed [SP_W:0]    sp_ext;
   logic signed [SP_W:0]    lim_pos;
   logic signed [SP_W:0]    lim_neg;
   logic signed [SP_W:0]    sp_clamped;
   logic signed [ERR_W-1:0] sp_times4;

   always_comb begin
      sp_ext  = (SP_W + 1)'(req_setpoint);
      lim_pos = $signed({2'b00, cfg.speed_cap});
      lim_neg = -lim_pos;

      // Clamp the setpoint magnitude in PID mode only
      sp_clamped = sp_ext;
      if (cfg.loop_mode == MODE_PID) begin
         if (sp_ext > lim_pos) begin
            sp_clamped = lim_pos;
         end else if (sp_ext < lim_neg) begin
            sp_clamped = lim_neg;
         end
      end

      sp_times4 = ERR_W'(sp_clamped) <<< 2;

      item.live = (req_setpoint != '0)
               && (req_setpoint <= SP_W'(SETPOINT_MAX))
               && (req_setpoint >= -SP_W'(SETPOINT_MAX));
      item.mode = cfg.loop_mode;
      item.err  = sp_times4 - ERR_W'(req_clicks);
   end

endmodule

### rtl/mvp_queue.sv
`include "motor_velocity_pid_unit_defines.svh"

module mvp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mvp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mvp_pkg::item_type head_item
);
   import mvp_pkg::*;

   item_type            entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop_ok;

   always_comb begin
      full       = (count_ff == QCNT_W'(QDEPTH));
      head_valid = (count_ff != '0);
      head_item  = entries_ff[rd_ptr_ff];
      push       = push_valid && !full;
      pop_ok     = pop && head_valid;

      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop_ok) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop_ok && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   `MVP_ASSERT_ALWAYS(a_q_bound, count_ff <= QCNT_W'(QDEPTH))

endmodule

### rtl/mvp_back.sv
`include "motor_velocity_pid_unit_defines.svh"

module mvp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mvp_pkg::cfg_type                  cfg,
   input  logic                              q_valid,
   input  mvp_pkg::item_type                 q_item,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [mvp_pkg::DRIVE_W-1:0] rsp_drive
);
   import mvp_pkg::*;

   // Loop state
   logic signed [ERR_W-1:0]   prev_error_ff, prev_error_in;
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic signed [ACC_W-1:0]   pd_accum_ff, pd_accum_in;

   // Pipeline stages
   logic            s1_valid_ff, s1_valid_in;
   state_stage_type s1_ff, s1_in;
   logic            s2_valid_ff, s2_valid_in;
   mult_stage_type  s2_ff, s2_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;

   logic                        adv;
   logic signed [INTEG_W:0]     integ_ext;
   logic signed [INTEG_W:0]     leak_corr;
   logic signed [INTEG_W:0]     leak_sum;
   logic [GAIN_W-1:0]           g_prop;
   logic [GAIN_W-1:0]           g_deriv;
   logic signed [SUM_W-1:0]     base;
   logic signed [SUM_W-1:0]     sum;
   logic signed [ACC_W-1:0]     clamped;

   always_comb begin
      adv   = !rsp_valid_ff || !rsp_stall;
      q_pop = adv;

      // State stage: delta and leaky integral
      integ_ext = (INTEG_W + 1)'(integral_ff);
      if (integral_ff[INTEG_W-1]) begin
         leak_corr = integ_ext >>> LEAK_SHIFT;
      end else begin
         leak_corr = (integ_ext + (INTEG_W + 1)'((1 << LEAK_SHIFT) - 1)) >>> LEAK_SHIFT;
      end
      leak_sum = integ_ext - leak_corr + (INTEG_W + 1)'(q_item.err);

      s1_in.live     = q_item.live;
      s1_in.mode     = q_item.mode;
      s1_in.err      = q_item.err;
      s1_in.delta    = DELTA_W'(q_item.err) - DELTA_W'(prev_error_ff);
      s1_in.integral = leak_sum[INTEG_W-1:0];
      s1_valid_in    = adv ? q_valid : s1_valid_ff;
      if (!adv) begin
         s1_in = s1_ff;
      end

      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      if (adv && q_valid && q_item.live) begin
         prev_error_in = q_item.err;
         if (q_item.mode == MODE_PID) begin
            integral_in = s1_in.integral;
         end
      end

      // Multiply stage
      g_prop  = (s1_ff.mode == MODE_PID) ? cfg.pid_prop_gain  : cfg.pd_prop_gain;
      g_deriv = (s1_ff.mode == MODE_PID) ? cfg.pid_deriv_gain : cfg.pd_deriv_gain;
      s2_in.live    = s1_ff.live;
      s2_in.mode    = s1_ff.mode;
      s2_in.m_prop  = s1_ff.err * $signed({1'b0, g_prop});
      s2_in.m_deriv = s1_ff.delta * $signed({1'b0, g_deriv});
      s2_in.m_int   = '0;
      if (s1_ff.mode == MODE_PID) begin
         s2_in.m_int = s1_ff.integral * $signed({1'b0, cfg.pid_int_gain});
      end
      s2_valid_in   = adv ? s1_valid_ff : s2_valid_ff;
      if (!adv) begin
         s2_in = s2_ff;
      end

      // Sum, clamp and scale stage
      base = (s2_ff.mode == MODE_PID) ? SUM_W'(s2_ff.m_int) : SUM_W'(pd_accum_ff);
      sum  = base + SUM_W'(s2_ff.m_prop) + SUM_W'(s2_ff.m_deriv);
      if (sum > SUM_W'(ACC_MAX)) begin
         clamped = ACC_MAX;
      end else if (sum < SUM_W'(ACC_MIN)) begin
         clamped = ACC_MIN;
      end else begin
         clamped = sum[ACC_W-1:0];
      end

      pd_accum_in = pd_accum_ff;
      if (adv && s2_valid_ff && s2_ff.live && (s2_ff.mode == MODE_PD)) begin
         pd_accum_in = clamped;
      end

      rsp_valid_in = adv ? s2_valid_ff : rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (adv) begin
         rsp_drive_in = s2_ff.live ? clamped[ACC_W-1:DRIVE_SHIFT] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
         pd_accum_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
         pd_accum_ff   <= pd_accum_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   `MVP_ASSERT_ALWAYS(a_acc_range, (pd_accum_ff <= ACC_MAX) && (pd_accum_ff >= ACC_MIN))
   `MVP_ASSERT_IMPLIES(a_drive_range, rsp_valid_ff, rsp_drive_ff >= -DRIVE_W'(127))
   `MVP_ASSERT_NEXT(a_dead_hold, adv && q_valid && !q_item.live, $stable(prev_error_ff) && $stable(integral_ff))

endmodule

### rtl/motor_velocity_pid_unit.sv
// Motor velocity loop, one request per control period.
// Request channel (req_): setpoint and encoder clicks, taken at an edge with
//   req_valid high and req_stall low. req_stall rises only when the internal
//   four-entry request queue is full.
// Response channel (rsp_): one drive value per request, in request order,
//   taken at an edge with rsp_valid high and rsp_stall low. A stop or
//   out-of-range setpoint yields drive 0 and leaves the loop state alone.
// CSR port: csr_wr_en writes csr_wdata to register csr_index at the edge;
//   indexes past the last register are dropped. Write only while idle.
// Path: the queue write happens on the accepting edge, then the state stage,
//   the multiply stage and sum/clamp into the output register. Throughput:
//   one request per cycle while rsp_stall is low; the error history, the leaky
//   integral and the PD accumulator are each updated in the stage that reads
//   them, which sets it.
// Stall: while rsp_stall holds a result, the back pipeline holds in place and
//   requests keep filling the queue until it is full.
// Reset (synchronous): registers return to defaults (PID mode, limit 25),
//   loop state clears to zero, queue and pipeline empty.
module motor_velocity_pid_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mvp_pkg::SP_W-1:0]      req_setpoint,
   input  logic signed [mvp_pkg::CLICKS_W-1:0]  req_clicks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mvp_pkg::DRIVE_W-1:0]   rsp_drive,
   input  logic                                 csr_wr_en,
   input  logic [mvp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mvp_pkg::CSR_W-1:0]            csr_wdata
);
   import mvp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_item;
   item_type head_item;
   logic     head_valid;
   logic     head_pop;
   logic     q_full;

   // Register file: decode the index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOOP_MODE:      cfg_in.loop_mode      = loop_mode_type'(csr_wdata[0]);
            CSR_SPEED_LIMIT:    cfg_in.speed_cap      = csr_wdata[LIMIT_W-1:0];
            CSR_PD_PROP_GAIN:   cfg_in.pd_prop_gain   = csr_wdata[GAIN_W-1:0];
            CSR_PD_DERIV_GAIN:  cfg_in.pd_deriv_gain  = csr_wdata[GAIN_W-1:0];
            CSR_PID_PROP_GAIN:  cfg_in.pid_prop_gain  = csr_wdata[GAIN_W-1:0];
            CSR_PID_INT_GAIN:   cfg_in.pid_int_gain   = csr_wdata[GAIN_W-1:0];
            CSR_PID_DERIV_GAIN: cfg_in.pid_deriv_gain = csr_wdata[GAIN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify the request and form the speed error
   mvp_front u_front (
      .req_setpoint (req_setpoint),
      .req_clicks   (req_clicks),
      .cfg          (cfg_ff),
      .item         (front_item)
   );

   // Queue decouples request intake from the back pipeline
   mvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_item  (front_item),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   assign req_stall = q_full;

   // Back: update loop state, multiply, sum and clamp, hold the response
   mvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (head_valid),
      .q_item    (head_item),
      .q_pop     (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_drive (rsp_drive)
   );

endmodule
